[src/pdls_pkg.sv]
// shared constants, types and codes for the press duration led sequencer
package pdls_pkg;

	localparam int LED_COUNT = 8;
	localparam int TIME_BITS = 32;
	localparam int LIMIT_BITS = 32;
	localparam int DEBOUNCE_BITS = 16;
	localparam int STEP_BITS = 16;
	localparam int COUNT_BITS = 8;
	localparam int CMP_BITS = (TIME_BITS > LIMIT_BITS) ? TIME_BITS : LIMIT_BITS;

	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [CFG_INDEX_BITS-1:0] REG_DEBOUNCE_MS = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SHORT_LIMIT = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LONG_LIMIT = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_PERIOD = 2'd3;

	localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [LIMIT_BITS-1:0] SHORT_RESET = 32'd1000;
	localparam logic [LIMIT_BITS-1:0] LONG_RESET = 32'd5000;
	localparam logic [STEP_BITS-1:0] STEP_RESET = 16'd1000;

	localparam logic [COUNT_BITS-1:0] COUNT_TOP = 8'd255;

	typedef logic [TIME_BITS-1:0] time_t;
	typedef logic [LED_COUNT-1:0] led_t;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_KEY1   = 2'd1,
		CMD_KEY2   = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_TOGGLE   = 3'd1,
		EV_UP       = 3'd2,
		EV_DOWN     = 3'd3,
		EV_BOUNDARY = 3'd4,
		EV_CLEAR    = 3'd5
	} event_t;

	typedef enum logic [1:0] {
		ACT_BOUNDARY = 2'd0,
		ACT_TOGGLE   = 2'd1,
		ACT_UP       = 2'd2,
		ACT_DOWN     = 2'd3
	} action_t;

	typedef struct packed {
		logic [DEBOUNCE_BITS-1:0] debounce_ms;
		logic [LIMIT_BITS-1:0]    short_limit;
		logic [LIMIT_BITS-1:0]    long_limit;
		logic [STEP_BITS-1:0]     step_period;
	} cfg_t;

	typedef struct packed {
		logic [7:0] led_pattern;
		logic       counting;
		event_t     event_code;
	} result_t;

endpackage

[src/pdls_classify.sv]
// press duration classifier: picks the action for a finished press
module pdls_classify (
	input  pdls_pkg::time_t                       duration,
	input  logic [pdls_pkg::LIMIT_BITS-1:0]       short_limit,
	input  logic [pdls_pkg::LIMIT_BITS-1:0]       long_limit,
	output pdls_pkg::action_t                     action
);
	import pdls_pkg::*;

	logic [CMP_BITS-1:0] dur_w;
	logic [CMP_BITS-1:0] short_w;
	logic [CMP_BITS-1:0] long_w;

	assign dur_w = CMP_BITS'(duration);
	assign short_w = CMP_BITS'(short_limit);
	assign long_w = CMP_BITS'(long_limit);

	// ranges are tested in order, first match wins
	always_comb begin
		priority if (dur_w != '0 && dur_w < short_w) begin
			action = ACT_TOGGLE;
		end else if (dur_w > short_w && dur_w < long_w) begin
			action = ACT_UP;
		end else if (dur_w > long_w) begin
			action = ACT_DOWN;
		end else begin
			action = ACT_BOUNDARY;
		end
	end

endmodule

[src/pdls_core.sv]
// sequencer state and single pass next-state logic for one item
module pdls_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  pdls_pkg::cmd_t    cmd,
	input  logic              key_level,
	input  pdls_pkg::cfg_t    cfg,
	output pdls_pkg::result_t result
);
	import pdls_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_UP   = 2'd1,
		MODE_DOWN = 2'd2
	} mode_t;

	time_t                 now_q, now_n;
	time_t                 last_q, last_n;
	time_t                 press_q, press_n;
	logic                  held_q, held_n;
	led_t                  led_q, led_n;
	mode_t                 mode_q, mode_n;
	logic [STEP_BITS-1:0]  step_q, step_n;
	logic [COUNT_BITS-1:0] count_q, count_n;
	event_t                ev;

	time_t                 since;
	time_t                 duration;
	logic [STEP_BITS-1:0]  timer_inc;
	logic [COUNT_BITS-1:0] count_inc;
	logic [COUNT_BITS-1:0] count_dec;
	action_t               action;

	assign since = now_q - last_q;
	assign duration = now_q - press_q;
	assign timer_inc = step_q + 1'b1;
	assign count_inc = count_q + 1'b1;
	assign count_dec = count_q - 1'b1;

	pdls_classify u_classify (
		.duration    (duration),
		.short_limit (cfg.short_limit),
		.long_limit  (cfg.long_limit),
		.action      (action)
	);

	always_comb begin
		now_n = now_q;
		last_n = last_q;
		press_n = press_q;
		held_n = held_q;
		led_n = led_q;
		mode_n = mode_q;
		step_n = step_q;
		count_n = count_q;
		ev = EV_NONE;
		if (advance) begin
			unique case (cmd)
				CMD_TICK: begin
					now_n = now_q + 1'b1;
					if (mode_q != MODE_IDLE) begin
						step_n = timer_inc;
						if (timer_inc >= cfg.step_period) begin
							step_n = '0;
							if (mode_q == MODE_UP) begin
								if (count_q == COUNT_TOP) begin
									mode_n = MODE_IDLE;
								end else begin
									count_n = count_inc;
									led_n = led_t'(count_inc);
								end
							end else begin
								if (count_q == '0) begin
									mode_n = MODE_IDLE;
								end else begin
									count_n = count_dec;
									led_n = led_t'(count_dec);
								end
							end
						end
					end
				end
				CMD_KEY1: begin
					// debounce window measured from the last accepted edge
					if (CMP_BITS'(since) > CMP_BITS'(cfg.debounce_ms)) begin
						if (!key_level) begin
							if (!held_q) begin
								last_n = now_q;
								press_n = now_q;
								held_n = 1'b1;
							end
						end else if (held_q) begin
							last_n = now_q;
							held_n = 1'b0;
							mode_n = MODE_IDLE;
							unique case (action)
								ACT_TOGGLE: begin
									led_n = ~led_q;
									ev = EV_TOGGLE;
								end
								ACT_UP: begin
									mode_n = MODE_UP;
									count_n = '0;
									step_n = '0;
									led_n = '0;
									ev = EV_UP;
								end
								ACT_DOWN: begin
									mode_n = MODE_DOWN;
									count_n = COUNT_TOP;
									step_n = '0;
									led_n = led_t'(COUNT_TOP);
									ev = EV_DOWN;
								end
								ACT_BOUNDARY: begin
									ev = EV_BOUNDARY;
								end
							endcase
						end
					end
				end
				CMD_KEY2: begin
					mode_n = MODE_IDLE;
					led_n = '0;
					ev = EV_CLEAR;
				end
				CMD_UNUSED: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			last_q <= '0;
			press_q <= '0;
			held_q <= 1'b0;
			led_q <= '0;
			mode_q <= MODE_IDLE;
			step_q <= '0;
			count_q <= '0;
		end else begin
			now_q <= now_n;
			last_q <= last_n;
			press_q <= press_n;
			held_q <= held_n;
			led_q <= led_n;
			mode_q <= mode_n;
			step_q <= step_n;
			count_q <= count_n;
		end
	end

	assign result.led_pattern = 8'(led_n);
	assign result.counting = (mode_n != MODE_IDLE);
	assign result.event_code = ev;

	a_key2_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd == CMD_KEY2 |=> mode_q == MODE_IDLE && led_q == '0)
		else $error("key 2 event did not stop the count and clear the leds");

	a_tick_advances_time: assert property (@(posedge clk) disable iff (!arst_n)
		advance && cmd == CMD_TICK |=> now_q == $past(now_q) + 1'b1)
		else $error("tick did not advance the time counter");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(now_q) && $stable(mode_q) && $stable(led_q) && $stable(held_q))
		else $error("state changed without an item");

	a_press_marks_edge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(held_q) |-> press_q == last_q)
		else $error("press start and last edge time disagree");

	a_start_needs_release: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE && mode_n != MODE_IDLE |-> cmd == CMD_KEY1 && held_q && key_level)
		else $error("count started without an accepted release");

endmodule

[src/press_duration_led_sequencer_top.sv]
// top level of the press duration led sequencer: ports, config registers, pipeline registers
//
// The block takes one item per clock while the result side keeps up: a
// millisecond tick, a key 1 edge with its pin level, or a key 2 event.
// Every item produces exactly one result carrying the led pattern after the
// item, a counting flag and an event code. An accepted item sits in an input
// register, is worked in a single combinational pass against the sequencer
// state and lands in the result register, where its result becomes valid;
// a new item can be taken in every cycle as long as the result side keeps up.
// The result register decouples the two sides: while a result waits, the
// input register still holds one more item. Configuration registers
// (debounce_ms, short_limit, long_limit, step_period) load on any cycle with
// cfg_write high and take effect for the next item worked; write them only
// while no item is in flight.
module press_duration_led_sequencer_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           command,
	input  logic                                 key_level,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [7:0]                           led_pattern,
	output logic                                 counting,
	output logic [2:0]                           event_code,
	// configuration write port
	input  logic                                 cfg_write,
	input  logic [pdls_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [pdls_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import pdls_pkg::*;

	// configuration registers
	cfg_t    cfg_q;

	// input register stage
	logic    valid_s1;
	cmd_t    cmd_s1;
	logic    level_s1;

	// result register
	logic    out_valid_q;
	result_t result_q;

	result_t result;
	logic    advance;

	// the stage moves on when the result register is empty or being emptied
	assign advance = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RESET;
			cfg_q.short_limit <= SHORT_RESET;
			cfg_q.long_limit <= LONG_RESET;
			cfg_q.step_period <= STEP_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_DEBOUNCE_MS: cfg_q.debounce_ms <= cfg_data[DEBOUNCE_BITS-1:0];
				REG_SHORT_LIMIT: cfg_q.short_limit <= cfg_data[LIMIT_BITS-1:0];
				REG_LONG_LIMIT:  cfg_q.long_limit <= cfg_data[LIMIT_BITS-1:0];
				REG_STEP_PERIOD: cfg_q.step_period <= cfg_data[STEP_BITS-1:0];
			endcase
		end
	end

	// input register: valid cleared by reset, payload loaded on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_t'(command);
			level_s1 <= key_level;
		end
	end

	pdls_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.cmd       (cmd_s1),
		.key_level (level_s1),
		.cfg       (cfg_q),
		.result    (result)
	);

	// result register: filled when the stage advances, drained on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign led_pattern = result_q.led_pattern;
	assign counting = result_q.counting;
	assign event_code = result_q.event_code;

endmodule
